FILE: rtl/contiguous_fit_allocator_core_assert.svh
// Assertion macros for the contiguous fit allocator.
// Included by the top level; the macros expand to nothing when SYNTHESIS is defined.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define CFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
// Next-cycle implication, held off during reset.
`define CFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define CFA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CFA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/cfa_pkg.sv
// Shared constants for the contiguous fit allocator: result codes,
// placement rule codes, register indexes and parameter defaults. No dependencies.
package cfa_pkg;

  localparam int DEF_MAX_BLOCKS  = 64;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ADDR_BITS   = 16;

  localparam int DUR_W    = 16;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  // Result codes.
  localparam logic [STATUS_W-1:0] ST_TICK_IDLE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TICK_ALLOC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TICK_NOFIT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TICK_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd5;

  // Placement rules.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MEMORY = 2'd1;

endpackage

FILE: rtl/cfa_fifo.sv
// Waiting request queue of the contiguous fit allocator.
// Register array with head and tail pointers; depends on nothing else.
module cfa_fifo #(
  parameter int DEPTH = 16,
  parameter int DW    = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       push,
  input  logic                       pop,
  input  logic [DW-1:0]              push_data,
  output logic [DW-1:0]              head_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;

  // Pointer step with wrap at the queue depth.
  function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign head_data = slots[head];
  assign full      = (count == CW'(DEPTH));

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= step(tail);
      end
      if (pop) begin
        head <= step(head);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

FILE: rtl/contiguous_fit_allocator_core.sv
// Contiguous fit allocator: block table with first, best, worst or next fit.
// An arrival item goes from idle to the done state, which registers its result and reopens the input.
// A tick runs the merge, search, shift-insert and statistics passes, each stepping through
// the table entries over the single registered read port. Next fit first reduces the search
// start modulo the table size, and a waiting result holds the block in the done state.
// Reset (synchronous) and a write of total_memory pass through the init state, which
// writes the first table entry before the first item is accepted.
`include "contiguous_fit_allocator_core_assert.svh"
module contiguous_fit_allocator_core #(
  parameter int MAX_BLOCKS  = cfa_pkg::DEF_MAX_BLOCKS,
  parameter int QUEUE_DEPTH = cfa_pkg::DEF_QUEUE_DEPTH,
  parameter int ADDR_BITS   = cfa_pkg::DEF_ADDR_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ADDR_BITS:0]               cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic [ADDR_BITS:0]               req_size,
  input  logic [cfa_pkg::DUR_W-1:0]        req_duration,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cfa_pkg::STATUS_W-1:0]     status,
  output logic [ADDR_BITS-1:0]             alloc_start,
  output logic [ADDR_BITS:0]               free_total,
  output logic [ADDR_BITS:0]               largest_free,
  output logic [cfa_pkg::CNT_W-1:0]        success_count,
  output logic [cfa_pkg::CNT_W-1:0]        leftover_total,
  output logic [cfa_pkg::CNT_W-1:0]        tick_count,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] waiting_count,
  output logic                             all_released
);
  import cfa_pkg::*;

  localparam int SW  = ADDR_BITS + 1;
  localparam int BW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int QDW = SW + DUR_W;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SW-1:0] MEM_MAX = {1'b1, {ADDR_BITS{1'b0}}};

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MRD, S_MMRG, S_MEND, S_MOD, S_FRD, S_FCHK, S_PLACE,
    S_SHIFT, S_SWR, S_ALLOC, S_TRD, S_TACC, S_DONE
  } state_t;

  state_t state;

  // Configuration.
  logic [1:0]    policy;
  logic [SW-1:0] total;

  // Block table memory, one registered read port and one write port.
  logic [ADDR_BITS-1:0] mem_start [MAX_BLOCKS];
  logic [SW-1:0]        mem_len   [MAX_BLOCKS];
  logic                 mem_used  [MAX_BLOCKS];
  logic [CNT_W-1:0]     mem_end   [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] rd_start;
  logic [SW-1:0]        rd_len;
  logic                 rd_used;
  logic [CNT_W-1:0]     rd_end;
  logic                 rd_en;
  logic [BW-1:0]        rd_addr;
  logic                 wr_en;
  logic [BW-1:0]        wr_addr;
  logic [ADDR_BITS-1:0] wr_start;
  logic [SW-1:0]        wr_len;
  logic                 wr_used;
  logic [CNT_W-1:0]     wr_end;

  // Sequencer registers.
  logic [CW-1:0]        blk_count;
  logic [BW-1:0]        nf_ptr;
  logic [CNT_W-1:0]     cur_time;
  logic [CNT_W-1:0]     alloc_cnt;
  logic [CNT_W-1:0]     left_sum;
  logic [CNT_W-1:0]     tick_cnt;
  logic [CW-1:0]        scan_i;
  logic [CW-1:0]        scan_k;
  logic [CW-1:0]        wr_ptr;
  logic [CW-1:0]        shift_j;
  logic                 pend_valid;
  logic [ADDR_BITS-1:0] pend_start;
  logic [SW-1:0]        pend_len;
  logic                 pend_used;
  logic [CNT_W-1:0]     pend_end;
  logic                 found;
  logic [BW-1:0]        fidx;
  logic [ADDR_BITS-1:0] fstart;
  logic [SW-1:0]        flen;
  logic [SW-1:0]        acc_free;
  logic [SW-1:0]        acc_max;
  logic                 acc_rel;
  logic [SW-1:0]        st_free;
  logic [SW-1:0]        st_max;
  logic                 st_rel;
  logic [STATUS_W-1:0]  res_status;
  logic [ADDR_BITS-1:0] res_start;

  // Queue interface.
  logic           q_clear;
  logic           q_push;
  logic           q_pop;
  logic [QDW-1:0] q_head;
  logic [QCW-1:0] q_count;
  logic           q_full;
  logic [SW-1:0]  head_size;
  logic [DUR_W-1:0] head_dur;

  // Combinational helpers.
  logic          e_used;
  logic          mergeable;
  logic          fits;
  logic          take;
  logic          last_k;
  logic [SW-1:0] left;
  logic [SW-1:0] cfg_total;
  logic [CNT_W:0] left_add;
  logic [CW-1:0] fidx_inc;

  cfa_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .DW    (QDW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .clear     (q_clear),
    .push      (q_push),
    .pop       (q_pop),
    .push_data ({req_duration, req_size}),
    .head_data (q_head),
    .count     (q_count),
    .full      (q_full)
  );

  assign head_size = q_head[SW-1:0];
  assign head_dur  = q_head[QDW-1:SW];
  assign in_ready  = (state == S_IDLE);
  assign q_clear   = (state == S_INIT);
  assign q_push    = in_valid && in_ready && mode && !q_full;
  assign q_pop     = (state == S_ALLOC);

  // Per-entry decisions on the registered read data.
  assign e_used    = rd_used && (rd_end != cur_time);
  assign mergeable = pend_valid && !pend_used && !e_used;
  assign fits      = !rd_used && (rd_len >= head_size);
  assign last_k    = (scan_k + 1'b1 == blk_count);
  assign left      = flen - head_size;
  assign left_add  = {1'b0, left_sum} + (CNT_W+1)'(left);
  assign fidx_inc  = CW'(fidx) + 1'b1;

  always_comb begin
    take = 1'b0;
    if (fits) begin
      case (policy)
        FIT_BEST:  take = !found || (rd_len < flen);
        FIT_WORST: take = !found || (rd_len > flen);
        default:   take = 1'b1;
      endcase
    end
  end

  // Clamp of a written memory size.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_total = SW'(1);
    end else if (cfg_data > MEM_MAX) begin
      cfg_total = MEM_MAX;
    end else begin
      cfg_total = cfg_data;
    end
  end

  // Table read address.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_i[BW-1:0];
    case (state)
      S_MRD, S_FRD, S_TRD: rd_en = 1'b1;
      S_SHIFT: begin
        rd_en   = (shift_j > fidx_inc);
        rd_addr = BW'(shift_j - 1'b1);
      end
      default: rd_en = 1'b0;
    endcase
  end

  // Table write port.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = wr_ptr[BW-1:0];
    wr_start = pend_start;
    wr_len   = pend_len;
    wr_used  = pend_used;
    wr_end   = pend_end;
    case (state)
      S_INIT: begin
        wr_en    = 1'b1;
        wr_addr  = '0;
        wr_start = '0;
        wr_len   = total;
        wr_used  = 1'b0;
        wr_end   = '0;
      end
      S_MMRG: wr_en = pend_valid && !mergeable;
      S_MEND: wr_en = 1'b1;
      S_SWR: begin
        wr_en    = 1'b1;
        wr_addr  = shift_j[BW-1:0];
        wr_start = rd_start;
        wr_len   = rd_len;
        wr_used  = rd_used;
        wr_end   = rd_end;
      end
      S_SHIFT: begin
        wr_en    = !(shift_j > fidx_inc);
        wr_addr  = fidx_inc[BW-1:0];
        wr_start = fstart + head_size[ADDR_BITS-1:0];
        wr_len   = left;
        wr_used  = 1'b0;
        wr_end   = '0;
      end
      S_ALLOC: begin
        wr_en    = 1'b1;
        wr_addr  = fidx;
        wr_start = fstart;
        wr_len   = head_size;
        wr_used  = 1'b1;
        wr_end   = cur_time + CNT_W'(head_dur);
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Table memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
      mem_used[wr_addr]  <= wr_used;
      mem_end[wr_addr]   <= wr_end;
    end
    if (rd_en) begin
      rd_start <= mem_start[rd_addr];
      rd_len   <= mem_len[rd_addr];
      rd_used  <= mem_used[rd_addr];
      rd_end   <= mem_end[rd_addr];
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      policy     <= FIT_FIRST;
      total      <= MEM_MAX;
      out_valid  <= 1'b0;
      blk_count  <= CW'(1);
      nf_ptr     <= '0;
      cur_time   <= '0;
      alloc_cnt  <= '0;
      left_sum   <= '0;
      tick_cnt   <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
    end else begin
      // A taken result clears the valid unless a new one is loaded.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      // Register writes; a new memory size restarts the table.
      if (cfg_we && cfg_index == REG_FIT_POLICY) begin
        policy <= cfg_data[1:0];
      end
      if (cfg_we && cfg_index == REG_TOTAL_MEMORY) begin
        total <= cfg_total;
        state <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            blk_count <= CW'(1);
            nf_ptr    <= '0;
            cur_time  <= '0;
            alloc_cnt <= '0;
            left_sum  <= '0;
            tick_cnt  <= '0;
            st_free   <= total;
            st_max    <= total;
            st_rel    <= 1'b1;
            state     <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              res_start <= '0;
              if (mode) begin
                res_status <= q_full ? ST_DROPPED : ST_QUEUED;
                state      <= S_DONE;
              end else begin
                res_status <= ST_TICK_IDLE;
                scan_i     <= '0;
                wr_ptr     <= '0;
                pend_valid <= 1'b0;
                state      <= S_MRD;
              end
            end
          end
          // Free expired blocks and merge free neighbours, compacting in place.
          S_MRD: state <= S_MMRG;
          S_MMRG: begin
            if (mergeable) begin
              pend_len <= pend_len + rd_len;
            end else begin
              if (pend_valid) begin
                wr_ptr <= wr_ptr + 1'b1;
              end
              pend_start <= rd_start;
              pend_len   <= rd_len;
              pend_used  <= e_used;
              pend_end   <= rd_end;
              pend_valid <= 1'b1;
            end
            if (scan_i + 1'b1 == blk_count) begin
              state <= S_MEND;
            end else begin
              scan_i <= scan_i + 1'b1;
              state  <= S_MRD;
            end
          end
          S_MEND: begin
            blk_count <= wr_ptr + 1'b1;
            found     <= 1'b0;
            scan_k    <= '0;
            if (q_count == '0) begin
              scan_i   <= '0;
              acc_free <= '0;
              acc_max  <= '0;
              acc_rel  <= 1'b1;
              state    <= S_TRD;
            end else if (policy == FIT_NEXT) begin
              scan_i <= CW'(nf_ptr);
              state  <= S_MOD;
            end else begin
              scan_i <= '0;
              state  <= S_FRD;
            end
          end
          // Start of the next fit search, reduced modulo the table size.
          S_MOD: begin
            if (scan_i >= blk_count) begin
              scan_i <= scan_i - blk_count;
            end else begin
              state <= S_FRD;
            end
          end
          // Search for the block to place the queue head in.
          S_FRD: state <= S_FCHK;
          S_FCHK: begin
            if (take) begin
              found  <= 1'b1;
              fidx   <= scan_i[BW-1:0];
              fstart <= rd_start;
              flen   <= rd_len;
            end
            if (take && (policy == FIT_FIRST || policy == FIT_NEXT)) begin
              state <= S_PLACE;
            end else if (last_k) begin
              if (found || take) begin
                state <= S_PLACE;
              end else begin
                res_status <= ST_TICK_NOFIT;
                scan_i     <= '0;
                acc_free   <= '0;
                acc_max    <= '0;
                acc_rel    <= 1'b1;
                state      <= S_TRD;
              end
            end else begin
              scan_k <= scan_k + 1'b1;
              if (scan_i + 1'b1 == blk_count) begin
                scan_i <= '0;
              end else begin
                scan_i <= scan_i + 1'b1;
              end
              state <= S_FRD;
            end
          end
          S_PLACE: begin
            if (left != '0 && blk_count == CW'(MAX_BLOCKS)) begin
              res_status <= ST_TICK_FULL;
              scan_i     <= '0;
              acc_free   <= '0;
              acc_max    <= '0;
              acc_rel    <= 1'b1;
              state      <= S_TRD;
            end else begin
              if (policy == FIT_NEXT) begin
                nf_ptr <= (fidx_inc == blk_count) ? '0 : fidx_inc[BW-1:0];
              end
              shift_j <= blk_count;
              state   <= (left != '0) ? S_SHIFT : S_ALLOC;
            end
          end
          // Open a slot after the chosen block for the leftover.
          S_SHIFT: begin
            if (shift_j > fidx_inc) begin
              state <= S_SWR;
            end else begin
              blk_count <= blk_count + 1'b1;
              state     <= S_ALLOC;
            end
          end
          S_SWR: begin
            shift_j <= shift_j - 1'b1;
            state   <= S_SHIFT;
          end
          S_ALLOC: begin
            left_sum   <= left_add[CNT_W] ? '1 : left_add[CNT_W-1:0];
            alloc_cnt  <= (alloc_cnt == '1) ? alloc_cnt : alloc_cnt + 1'b1;
            res_start  <= fstart;
            res_status <= ST_TICK_ALLOC;
            scan_i     <= '0;
            acc_free   <= '0;
            acc_max    <= '0;
            acc_rel    <= 1'b1;
            state      <= S_TRD;
          end
          // Free total, largest free block and occupancy over the table.
          S_TRD: state <= S_TACC;
          S_TACC: begin
            if (rd_used) begin
              acc_rel <= 1'b0;
            end else begin
              acc_free <= acc_free + rd_len;
              if (rd_len > acc_max) begin
                acc_max <= rd_len;
              end
            end
            if (scan_i + 1'b1 == blk_count) begin
              st_free  <= rd_used ? acc_free : acc_free + rd_len;
              st_max   <= (!rd_used && rd_len > acc_max) ? rd_len : acc_max;
              st_rel   <= acc_rel && !rd_used;
              tick_cnt <= (tick_cnt == '1) ? tick_cnt : tick_cnt + 1'b1;
              cur_time <= cur_time + 1'b1;
              state    <= S_DONE;
            end else begin
              scan_i <= scan_i + 1'b1;
              state  <= S_TRD;
            end
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid      <= 1'b1;
              status         <= res_status;
              alloc_start    <= res_start;
              free_total     <= st_free;
              largest_free   <= st_max;
              success_count  <= alloc_cnt;
              leftover_total <= left_sum;
              tick_count     <= tick_cnt;
              waiting_count  <= q_count;
              all_released   <= st_rel;
              state          <= S_IDLE;
            end
          end
          default: state <= S_INIT;
        endcase
      end
    end
  end

  // The table never becomes empty and never outgrows its memory.
  `CFA_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, (blk_count != '0) && (blk_count <= CW'(MAX_BLOCKS)))
  // An accepted item closes the input side in the following cycle.
  `CFA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready && !cfg_we, !in_ready)
  // Only a successful placement removes a waiting request, and the queue is then never empty.
  `CFA_ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop, q_count != '0)

endmodule

FILE: bench/tb.sv
// Self-checking testbench for contiguous_fit_allocator_core: drives request and tick
// items, predicts every result with a behavioural allocator model and checks them.
// Depends on cfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

// One result item as seen on the output ports.
typedef struct {
  logic [2:0]  status;
  logic [15:0] start;
  logic [16:0] free_sum;
  logic [16:0] max_free;
  logic [31:0] allocs;
  logic [31:0] leftovers;
  logic [31:0] ticks;
  logic [4:0]  waiting;
  logic        none_used;
} alloc_result_t;

// Holds the expected results of accepted items and compares the outputs against them.
class alloc_scoreboard;
  // Predictor state.
  logic [1:0]  policy;
  logic [16:0] mem_size;
  logic [15:0] b_start [64];
  logic [16:0] b_len [64];
  logic        b_used [64];
  logic [31:0] b_end [64];
  int          n_blocks;
  int          nf_ptr;
  logic [31:0] now;
  logic [16:0] q_size [16];
  logic [15:0] q_dur [16];
  int          q_head;
  int          q_count;
  logic [31:0] alloc_cnt;
  logic [31:0] left_sum;
  logic [31:0] tick_cnt;
  alloc_result_t pending[$];
  int          errors;

  function new();
    errors = 0;
    policy = cfa_pkg::FIT_FIRST;
    mem_size = 17'h10000;
    clear_table();
  endfunction

  function void clear_table();
    for (int i = 0; i < 64; i++) begin
      b_start[i] = 0; b_len[i] = 0; b_used[i] = 0; b_end[i] = 0;
    end
    b_len[0] = mem_size;
    n_blocks = 1; nf_ptr = 0; now = 0; q_head = 0; q_count = 0;
    alloc_cnt = 0; left_sum = 0; tick_cnt = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [16:0] val);
    if (idx == cfa_pkg::REG_FIT_POLICY) begin
      policy = val[1:0];
    end else if (idx == cfa_pkg::REG_TOTAL_MEMORY) begin
      mem_size = (val == 0) ? 17'd1 : (val > 17'h10000 ? 17'h10000 : val);
      clear_table();
    end
  endfunction

  function logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Frees expired blocks and folds runs of free blocks together.
  function void release_and_merge();
    int w;
    w = 0;
    for (int i = 0; i < n_blocks; i++)
      if (b_used[i] && b_end[i] == now) b_used[i] = 0;
    for (int i = 0; i < n_blocks; i++) begin
      if (w > 0 && !b_used[w-1] && !b_used[i]) begin
        b_len[w-1] += b_len[i];
      end else begin
        b_start[w] = b_start[i]; b_len[w] = b_len[i];
        b_used[w] = b_used[i]; b_end[w] = b_end[i];
        w++;
      end
    end
    n_blocks = w;
  endfunction

  function int pick_block(logic [16:0] size);
    int idx, i;
    idx = n_blocks;
    if (policy == cfa_pkg::FIT_NEXT) begin
      for (int k = 0; k < n_blocks; k++) begin
        i = (nf_ptr + k) % n_blocks;
        if (!b_used[i] && b_len[i] >= size) return i;
      end
      return n_blocks;
    end
    for (i = 0; i < n_blocks; i++) begin
      if (b_used[i] || b_len[i] < size) continue;
      if (policy == cfa_pkg::FIT_FIRST) return i;
      if (idx == n_blocks ||
          (policy == cfa_pkg::FIT_BEST && b_len[i] < b_len[idx]) ||
          (policy == cfa_pkg::FIT_WORST && b_len[i] > b_len[idx]))
        idx = i;
    end
    return idx;
  endfunction

  // Notes an accepted item and queues the result it should cause.
  function void note_item(logic mode, logic [16:0] size, logic [15:0] dur);
    alloc_result_t r;
    int idx, n;
    logic [16:0] left;
    r.start = 0;
    if (mode) begin
      if (q_count < 16) begin
        q_size[(q_head + q_count) % 16] = size;
        q_dur[(q_head + q_count) % 16] = dur;
        q_count++;
        r.status = cfa_pkg::ST_QUEUED;
      end else begin
        r.status = cfa_pkg::ST_DROPPED;
      end
    end else begin
      r.status = cfa_pkg::ST_TICK_IDLE;
      release_and_merge();
      if (q_count > 0) begin
        n = n_blocks;
        idx = pick_block(q_size[q_head]);
        if (idx >= n) begin
          r.status = cfa_pkg::ST_TICK_NOFIT;
        end else begin
          left = b_len[idx] - q_size[q_head];
          if (left > 0 && n >= 64) begin
            r.status = cfa_pkg::ST_TICK_FULL;
          end else begin
            if (left > 0) begin
              for (int j = n; j > idx + 1; j--) begin
                b_start[j] = b_start[j-1]; b_len[j] = b_len[j-1];
                b_used[j] = b_used[j-1]; b_end[j] = b_end[j-1];
              end
              b_start[idx+1] = b_start[idx] + q_size[q_head][15:0];
              b_len[idx+1] = left;
              b_used[idx+1] = 0;
              b_end[idx+1] = 0;
              n_blocks = n + 1;
            end
            b_used[idx] = 1;
            b_len[idx] = q_size[q_head];
            b_end[idx] = now + q_dur[q_head];
            if (policy == cfa_pkg::FIT_NEXT) nf_ptr = (idx + 1) % n;
            left_sum = sat_inc(left_sum, left);
            alloc_cnt = sat_inc(alloc_cnt, 1);
            q_head = (q_head + 1) % 16;
            q_count--;
            r.start = b_start[idx];
            r.status = cfa_pkg::ST_TICK_ALLOC;
          end
        end
      end
      tick_cnt = sat_inc(tick_cnt, 1);
      now = now + 1;
    end
    r.free_sum = 0; r.max_free = 0; r.none_used = 1;
    for (int i = 0; i < n_blocks; i++) begin
      if (b_used[i]) begin
        r.none_used = 0;
      end else begin
        r.free_sum += b_len[i];
        if (b_len[i] > r.max_free) r.max_free = b_len[i];
      end
    end
    r.allocs = alloc_cnt; r.leftovers = left_sum; r.ticks = tick_cnt;
    r.waiting = q_count[4:0];
    pending = {pending, r};
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endfunction

  // Compares one accepted result with the oldest expectation.
  function void check_result(alloc_result_t g);
    alloc_result_t e;
    if (pending.size() == 0) begin
      $display("tb: result with nothing expected at %0t", $time);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (g.status !== e.status) report("status", g.status, e.status);
    if (g.start !== e.start) report("alloc_start", g.start, e.start);
    if (g.free_sum !== e.free_sum) report("free_total", g.free_sum, e.free_sum);
    if (g.max_free !== e.max_free) report("largest_free", g.max_free, e.max_free);
    if (g.allocs !== e.allocs) report("success_count", g.allocs, e.allocs);
    if (g.leftovers !== e.leftovers) report("leftover_total", g.leftovers, e.leftovers);
    if (g.ticks !== e.ticks) report("tick_count", g.ticks, e.ticks);
    if (g.waiting !== e.waiting) report("waiting_count", g.waiting, e.waiting);
    if (g.none_used !== e.none_used) report("all_released", g.none_used, e.none_used);
  endfunction
endclass

module tb;
  import cfa_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [16:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        mode = 0;
  logic [16:0] req_size = 0;
  logic [15:0] req_duration = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [15:0] alloc_start;
  logic [16:0] free_total, largest_free;
  logic [31:0] success_count, leftover_total, tick_count;
  logic [4:0]  waiting_count;
  logic        all_released;

  alloc_scoreboard sb = new();
  alloc_result_t res_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_off = 0;
  event hold_go;
  int quiet_cycles = 0;
  logic [16:0] mem_now = 17'h10000;

  contiguous_fit_allocator_core dut (.*);

  always #5 clk = ~clk;

  // Result side: random stalls, an optional long hold-off, checking on acceptance.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      res_seen.status = status; res_seen.start = alloc_start;
      res_seen.free_sum = free_total; res_seen.max_free = largest_free;
      res_seen.allocs = success_count; res_seen.leftovers = leftover_total;
      res_seen.ticks = tick_count; res_seen.waiting = waiting_count;
      res_seen.none_used = all_released;
      sb.check_result(res_seen);
    end
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here once it is requested.
  initial begin
    @(hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: ends the run after a long stretch with no accepted item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || cfg_we || hold_off)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Sends one item and notes it with the scoreboard once accepted.
  task automatic send_item(logic m, logic [16:0] sz, logic [15:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; mode <= m; req_size <= sz; req_duration <= dur;
    do @(posedge clk); while (!in_ready);
    sb.note_item(m, sz, dur);
  endtask

  // Writes a register once everything expected has come back and the block is quiet.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    if (idx == REG_TOTAL_MEMORY) mem_now = sb.mem_size;
  endtask

  // A random request, mostly sized to fit the memory, or a tick.
  task automatic random_item();
    logic [16:0] sz;
    logic [15:0] dur;
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      send_item(1'b0, '0, '0);
    end else begin
      case ($urandom_range(9))
        0: sz = 17'($urandom_range(17'h1FFFF));
        1: sz = '0;
        2: sz = mem_now;
        default: sz = 17'($urandom_range(1, (mem_now > 8) ? mem_now / 8 : mem_now));
      endcase
      case ($urandom_range(9))
        0: dur = 16'($urandom);
        1: dur = '0;
        default: dur = 16'($urandom_range(1, 40));
      endcase
      send_item(1'b1, sz, dur);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes of the fields, exact fit, zero size and duration, drops.
    send_item(1'b1, 17'h10000, 16'hFFFF);
    send_item(1'b0, '0, '0);
    send_item(1'b1, 17'h1FFFF, 16'd1);
    send_item(1'b0, 17'h1FFFF, 16'hFFFF);
    send_item(1'b1, '0, '0);
    send_item(1'b0, '0, '0);
    write_reg(REG_TOTAL_MEMORY, 17'd100);
    for (int i = 0; i < 18; i++) send_item(1'b1, 17'(10 + i), 16'd3);
    send_item(1'b0, '0, '0);
    send_item(1'b0, '0, '0);

    // Random phases over every placement rule, memory size and idling mix.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_FIT_POLICY, 17'(ph % 4));
      case (ph % 6)
        0: write_reg(REG_TOTAL_MEMORY, 17'h10000);
        1: write_reg(REG_TOTAL_MEMORY, 17'd1);
        2: write_reg(REG_TOTAL_MEMORY, 17'd0);
        3: write_reg(REG_TOTAL_MEMORY, 17'h1FFFF);
        default: write_reg(REG_TOTAL_MEMORY, 17'($urandom_range(64, 4000)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (ph == 4) -> hold_go;
      for (int i = 0; i < 110; i++) random_item();
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end
endmodule
